[sv/c8x_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8x_pkg: shared types and constants for the CHIP-8 instruction executor
// Action codes, fault codes, shared-unit operation codes and unit ports.
// ----------------------------------------------------------------------------
package c8x_pkg;

  localparam int MEM_BYTES_DEF     = 4096;
  localparam int SCREEN_WIDTH_DEF  = 64;
  localparam int SCREEN_HEIGHT_DEF = 32;
  localparam int STACK_DEPTH_DEF   = 16;

  localparam logic [11:0] OP_CLS     = 12'h0E0;
  localparam logic [11:0] OP_RET     = 12'h0EE;
  localparam logic [3:0]  FLAG_REG   = 4'hF;
  localparam logic [11:0] ADDR_MASK  = 12'hFFF;
  localparam logic [11:0] PC_RESET   = 12'd512;

  localparam logic [0:0]  CFG_SHIFT_VY = 1'b0;
  localparam logic [0:0]  CFG_PC_START = 1'b1;

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_EXEC = 2'd1,
    ACT_READ = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    FLT_NONE      = 2'd0,
    FLT_UNKNOWN   = 2'd1,
    FLT_OVERFLOW  = 2'd2,
    FLT_UNDERFLOW = 2'd3
  } fault_t;

  // shared ALU operations
  typedef enum logic [2:0] {
    ALU_PASS = 3'd0,
    ALU_OR   = 3'd1,
    ALU_AND  = 3'd2,
    ALU_XOR  = 3'd3,
    ALU_ADD  = 3'd4,
    ALU_SUB  = 3'd5,
    ALU_SHR  = 3'd6,
    ALU_SHL  = 3'd7
  } alu_op_t;

  typedef struct packed {
    alu_op_t    op;
    logic [7:0] a;
    logic [7:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [7:0] res;
    logic       flag;
    logic       eq;
  } alu_rsp_t;

endpackage

[sv/c8x_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8x_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module c8x_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[sv/c8x_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8x_alu: shared byte arithmetic unit
// Logic, add, subtract, shifts and equality for the register and skip instructions.
// ----------------------------------------------------------------------------
module c8x_alu
  import c8x_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [8:0] sum;
  logic [8:0] dif;

  always_comb begin
    sum = {1'b0, req.a} + {1'b0, req.b};
    dif = {1'b0, req.a} - {1'b0, req.b};
    rsp.eq = (req.a == req.b);
    rsp.flag = 1'b0;
    rsp.res = req.b;
    case (req.op)
      ALU_PASS: rsp.res = req.b;
      ALU_OR:   rsp.res = req.a | req.b;
      ALU_AND:  rsp.res = req.a & req.b;
      ALU_XOR:  rsp.res = req.a ^ req.b;
      ALU_ADD: begin
        rsp.res = sum[7:0];
        rsp.flag = sum[8];
      end
      ALU_SUB: begin
        rsp.res = dif[7:0];
        rsp.flag = ~dif[8];
      end
      ALU_SHR: begin
        rsp.res = {1'b0, req.a[7:1]};
        rsp.flag = req.a[0];
      end
      ALU_SHL: begin
        rsp.res = {req.a[6:0], 1'b0};
        rsp.flag = req.a[7];
      end
      default: rsp.res = req.b;
    endcase
  end

endmodule

[sv/chip8_instruction_executor_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chip8_instruction_executor_unit: CHIP-8 core
// Memory, registers, return stack and XOR framebuffer under one sequencer.
// ----------------------------------------------------------------------------
// One word in, one word out. A load or display read goes through the row
// read and output states. An instruction fetches its two bytes over the single
// memory port (S_F0, S_F1, S_F2) and then executes; 00E0 walks all SCREEN_HEIGHT
// framebuffer rows, and Dxyn passes each sprite row through S_DRD, S_DWAIT and
// S_DROW for the memory read and the row XOR. The input is stalled while a word is in
// work or its result still waits. Memory is not cleared after reset.
module chip8_instruction_executor_unit
  import c8x_pkg::*;
#(
  parameter int MEM_BYTES     = MEM_BYTES_DEF,
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  parameter int STACK_DEPTH   = STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [11:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [11:0] in_load_address,
  input  logic [7:0]  in_load_data,
  input  logic [4:0]  in_row_select,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [SCREEN_WIDTH-1:0] out_row_pixels,
  output logic [11:0] out_pc_value,
  output logic [11:0] out_index_value,
  output logic        out_refresh,
  output logic [1:0]  out_fault
);

  localparam int AW = $clog2(MEM_BYTES);
  localparam int RW = $clog2(SCREEN_HEIGHT);
  localparam int SW = $clog2(STACK_DEPTH + 1);
  localparam int SA = $clog2(STACK_DEPTH);
  localparam int XW = $clog2(SCREEN_WIDTH);

  typedef enum logic [3:0] {
    S_IDLE, S_F0, S_F1, S_F2, S_EXEC, S_CLS, S_DRD, S_DWAIT, S_DROW, S_RROW, S_OUT
  } state_t;

  state_t state_r;
  logic        shift_vy_r;
  logic [11:0] start_r;
  logic [7:0]  v_r [16];
  logic [11:0] i_r, pc_r;
  logic [11:0] stk_r [STACK_DEPTH];
  logic [SW-1:0] lvl_r;
  logic [SCREEN_WIDTH-1:0] fb_r [SCREEN_HEIGHT];
  logic [15:0] op_r;
  logic [4:0]  sel_r;
  logic [RW:0] cnt_r, rows_r;
  logic [RW-1:0] y_r;
  logic [XW-1:0] x_r;
  logic        hit_r, chg_r;
  logic        ovalid_r;
  logic [SCREEN_WIDTH-1:0] orow_r;
  logic        orefresh_r;
  logic [1:0]  ofault_r;
  logic        ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]  ram_rd;
  alu_req_t    areq;
  alu_rsp_t    arsp;

  c8x_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(in_load_data), .rdata(ram_rd)
  );

  c8x_alu u_alu (.req(areq), .rsp(arsp));

  logic [3:0] ox, oy, on;
  logic [7:0] vx, vy;
  logic [SCREEN_WIDTH-1:0] mask;

  always_comb begin
    ox = op_r[11:8];
    oy = op_r[7:4];
    on = op_r[3:0];
    vx = v_r[ox];
    vy = v_r[oy];
    mask = {ram_rd, {(SCREEN_WIDTH-8){1'b0}}} >> x_r;
    areq.a = vx;
    areq.b = vy;
    areq.op = alu_op_t'(on[2:0]);
    if (op_r[15:12] == 4'h3 || op_r[15:12] == 4'h4) areq.b = op_r[7:0];
    if (op_r[15:12] == 4'h7) begin
      areq.b = op_r[7:0];
      areq.op = ALU_ADD;
    end
    if (op_r[15:12] == 4'h8) begin
      if (on == 4'hE) areq.op = ALU_SHL;
      if ((on == 4'h6 || on == 4'hE) && shift_vy_r) areq.a = vy;
    end
    ram_we = 1'b0;
    ram_addr = pc_r[AW-1:0];
    case (state_r)
      S_IDLE: begin
        ram_we = in_valid && !in_stall && in_action == ACT_LOAD;
        ram_addr = ram_we ? in_load_address[AW-1:0] : pc_r[AW-1:0];
      end
      S_F1: ram_addr = pc_r[AW-1:0] + AW'(1);
      S_DRD, S_DWAIT, S_DROW: ram_addr = AW'(i_r + 12'(cnt_r));
      default: ram_addr = pc_r[AW-1:0];
    endcase
  end

  assign in_stall = (state_r != S_IDLE) || ovalid_r;
  assign out_valid = ovalid_r;
  assign out_row_pixels = orow_r;
  assign out_pc_value = pc_r;
  assign out_index_value = i_r;
  assign out_refresh = orefresh_r;
  assign out_fault = ofault_r;

  logic [11:0] nxt;
  assign nxt = pc_r + 12'd2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      shift_vy_r <= 1'b0;
      start_r <= PC_RESET;
      pc_r <= PC_RESET;
      i_r <= '0;
      lvl_r <= '0;
      ovalid_r <= 1'b0;
      for (int k = 0; k < 16; k++) v_r[k] <= '0;
      for (int k = 0; k < SCREEN_HEIGHT; k++) fb_r[k] <= '0;
    end else begin
      // the start value is only stored in start_r; the PC is never loaded from it
      if (cfg_we) begin
        if (cfg_index == CFG_SHIFT_VY) shift_vy_r <= cfg_data[0];
        else start_r <= cfg_data;
      end
      if (ovalid_r && !out_stall) ovalid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_valid && !in_stall) begin
          sel_r <= in_row_select;
          orefresh_r <= 1'b0;
          ofault_r <= FLT_NONE;
          state_r <= (in_action == ACT_EXEC) ? S_F0 : S_RROW;
        end
        S_F0: state_r <= S_F1;
        S_F1: begin
          op_r[15:8] <= ram_rd;
          state_r <= S_F2;
        end
        S_F2: begin
          op_r[7:0] <= ram_rd;
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          state_r <= S_RROW;
          pc_r <= nxt;
          case (op_r[15:12])
            4'h0: begin
              if (op_r[11:0] == OP_CLS) begin
                cnt_r <= '0;
                state_r <= S_CLS;
              end else if (op_r[11:0] == OP_RET) begin
                if (lvl_r == '0) begin
                  ofault_r <= FLT_UNDERFLOW;
                  pc_r <= pc_r;
                end else begin
                  lvl_r <= lvl_r - SW'(1);
                  pc_r <= stk_r[SA'(lvl_r - SW'(1))];
                end
              end else begin
                ofault_r <= FLT_UNKNOWN;
                pc_r <= pc_r;
              end
            end
            4'h1: pc_r <= op_r[11:0];
            4'h2: begin
              if (lvl_r >= SW'(STACK_DEPTH)) begin
                ofault_r <= FLT_OVERFLOW;
                pc_r <= pc_r;
              end else begin
                stk_r[SA'(lvl_r)] <= nxt;
                lvl_r <= lvl_r + SW'(1);
                pc_r <= op_r[11:0];
              end
            end
            4'h3, 4'h5: if (arsp.eq) pc_r <= nxt + 12'd2;
            4'h4, 4'h9: if (!arsp.eq) pc_r <= nxt + 12'd2;
            4'h6: v_r[ox] <= op_r[7:0];
            4'h7: v_r[ox] <= arsp.res;
            4'h8: begin
              if (on inside {[4'h0:4'h6], 4'hE}) begin
                v_r[ox] <= arsp.res;
                if (on inside {[4'h4:4'h6], 4'hE}) v_r[FLAG_REG] <= {7'd0, arsp.flag};
              end else begin
                ofault_r <= FLT_UNKNOWN;
                pc_r <= pc_r;
              end
            end
            4'hA: i_r <= op_r[11:0];
            4'hD: begin
              x_r <= vx[XW-1:0];
              y_r <= vy[RW-1:0];
              rows_r <= ((RW+1)'(on) > (RW+1)'(SCREEN_HEIGHT) - (RW+1)'(vy[RW-1:0]))
                ? (RW+1)'(SCREEN_HEIGHT) - (RW+1)'(vy[RW-1:0]) : (RW+1)'(on);
              cnt_r <= '0;
              hit_r <= 1'b0;
              chg_r <= 1'b0;
              state_r <= S_DRD;
            end
            default: begin
              ofault_r <= FLT_UNKNOWN;
              pc_r <= pc_r;
            end
          endcase
        end
        S_CLS: begin
          fb_r[RW'(cnt_r)] <= '0;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == (RW+1)'(SCREEN_HEIGHT - 1)) state_r <= S_RROW;
        end
        S_DRD: begin
          if (cnt_r == rows_r) begin
            v_r[FLAG_REG] <= {7'd0, hit_r};
            orefresh_r <= chg_r;
            state_r <= S_RROW;
          end else state_r <= S_DWAIT;
        end
        S_DWAIT: state_r <= S_DROW;
        S_DROW: begin
          if ((fb_r[y_r + RW'(cnt_r)] & mask) != '0) hit_r <= 1'b1;
          if (mask != '0) chg_r <= 1'b1;
          fb_r[y_r + RW'(cnt_r)] <= fb_r[y_r + RW'(cnt_r)] ^ mask;
          cnt_r <= cnt_r + 1'b1;
          state_r <= S_DRD;
        end
        S_RROW: begin
          orow_r <= fb_r[sel_r[RW-1:0]];
          state_r <= S_OUT;
        end
        S_OUT: begin
          ovalid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
